FILE: src/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
`default_nettype none

package swm_pkg;

	// configuration port
	localparam int APB_DW    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_WINDOW_SIZE = reg_idx_t'(0);

	// window_size register
	localparam int WIN_W = 6;

	typedef logic [WIN_W-1:0] win_t;

	localparam win_t WIN_RESET = win_t'(1);

endpackage : swm_pkg

`default_nettype wire

FILE: src/sliding_window_median_core.sv
// Sliding window median filter: sample stream in, lower median stream out.
//
// Usage:
//  - s_tvalid/s_tready/s_tdata carry one signed sample per word. m_tvalid/m_tready/m_tdata
//    carry one lower median per word.
//  - window_size (APB register 0, bits [5:0]) picks how many recent samples form the window.
//    A 0 gives 1, and values above WINDOW_MAX are clamped. Write it only while the stream is idle.
//  - No word is produced until window_size samples have arrived since reset. After that,
//    every sample gives one median. A window of 1 passes the samples straight through.
//  - A sample is registered at the input, shifted into the window, and its median is then
//    registered at the output. Throughput: one word per clock while the output is not stalled.
//    The rank of each entry is kept in a pairwise order matrix. Each new sample is compared
//    against every stored sample as it enters the matrix; the ranks are then counted to pick the median.
//  - Reset clears the fill count, sets window_size to 1 and empties the pipeline.
//    Stored samples are not cleared.
//  - While the receiver stalls, the held result stays stable. Input words are still taken
//    until the two internal stages fill. After that, s_tready stays low until m_tready returns.
`default_nettype none

module sliding_window_median_core #(
	parameter int WINDOW_MAX  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [swm_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [swm_pkg::APB_DW-1:0]         pwdata,
	output      logic [swm_pkg::APB_DW-1:0]         prdata,
	output      logic                               pready,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,  // sample
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata   // median
);

	import swm_pkg::*;

	localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CW  = $clog2(WINDOW_MAX + 1);
	localparam int FW  = (CW > WIN_W) ? CW : WIN_W;
	localparam int LV  = $clog2(WINDOW_MAX);
	localparam int PN  = 1 << LV;

	// tree popcount, one level of independent adds per step
	function automatic logic [CW-1:0] pop_cnt(input logic [WINDOW_MAX-1:0] bits);
		logic [PN-1:0] pb;
		logic [CW-1:0] acc [PN];
		pb = PN'(bits);
		for (int k = 0; k < PN; k++) begin
			acc[k] = CW'(pb[k]);
		end
		for (int l = 0; l < LV; l++) begin
			for (int k = 0; k < (PN >> (l + 1)); k++) begin
				acc[k] = acc[2*k] + acc[2*k+1];
			end
		end
		return acc[0];
	endfunction

	// configuration
	win_t     win_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic [FW-1:0] wr_val;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign wr_val  = FW'(pwdata[WIN_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WINDOW_SIZE: begin
					if (wr_val == '0)
						win_q <= win_t'(1);
					else if (wr_val > FW'(WINDOW_MAX))
						win_q <= win_t'(WINDOW_MAX);
					else
						win_q <= pwdata[WIN_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_SIZE: prdata = APB_DW'(win_q);
			default:         prdata = '0;
		endcase
	end

	// pipeline control
	logic                   v_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic                   p_s2;
	win_t                   w_s2;
	logic                   out_vld_q;
	logic [SAMPLE_BITS-1:0] med_q;
	logic [SAMPLE_BITS-1:0] med_sel;
	logic                   out_adv;
	logic                   s2_adv;
	logic                   upd;

	assign out_adv  = !out_vld_q || m_tready;
	assign s2_adv   = !p_s2 || out_adv;
	assign s_tready = !v_s1 || s2_adv;
	assign upd      = v_s1 && s2_adv;

	// window state: val_q[0] is the newest sample
	// lt_q[j][i] set when entry i sorts below entry j (ties: older is lower)
	logic [SAMPLE_BITS-1:0] val_q [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]  lt_q  [WINDOW_MAX];
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          fill_nxt;
	logic [WINDOW_MAX-1:0]  le_new;
	logic                   emit;

	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			le_new[i] = $signed(val_q[i]) <= $signed(smp_s1);
		end
	end

	assign fill_nxt = (fill_q < CW'(WINDOW_MAX)) ? CW'(fill_q + 1'b1) : fill_q;
	assign emit     = FW'(fill_nxt) >= FW'(win_q);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			smp_s1 <= s_tdata[SAMPLE_BITS-1:0];
		if (upd) begin
			w_s2 <= win_q;
			val_q[0] <= smp_s1;
			lt_q[0][0] <= 1'b0;
			for (int i = 1; i < WINDOW_MAX; i++) begin
				val_q[i]    <= val_q[i-1];
				lt_q[0][i]  <= le_new[i-1];
			end
			for (int j = 1; j < WINDOW_MAX; j++) begin
				lt_q[j][0] <= !le_new[j-1];
				for (int i = 1; i < WINDOW_MAX; i++) begin
					lt_q[j][i] <= lt_q[j-1][i-1];
				end
			end
		end
		if (out_adv && p_s2)
			med_q <= med_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			p_s2      <= 1'b0;
			out_vld_q <= 1'b0;
			fill_q    <= '0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (s2_adv)
				p_s2 <= upd && emit;
			if (out_adv)
				out_vld_q <= p_s2;
			if (upd)
				fill_q <= fill_nxt;
		end
	end

	// rank count and median pick over the current window
	logic [WINDOW_MAX-1:0]  win_mask;
	win_t                   target;

	assign target = (w_s2 - win_t'(1)) >> 1;

	always_comb begin : rank_blk
		logic [CW-1:0] rank;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			win_mask[i] = FW'(i) < FW'(w_s2);
		end
		med_sel = '0;
		for (int j = 0; j < WINDOW_MAX; j++) begin
			rank = pop_cnt(lt_q[j] & win_mask);
			if (win_mask[j] && (FW'(rank) == FW'(target)))
				med_sel = med_sel | val_q[j];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = TDW'(med_q);

endmodule : sliding_window_median_core

`default_nettype wire

FILE: src/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to the top level.
`default_nettype none

module swm_checker #(
	parameter int WINDOW_MAX  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               psel,
	input wire logic                               penable,
	input wire logic                               pwrite,
	input wire logic [swm_pkg::ADDR_W-1:0]         paddr,
	input wire logic [swm_pkg::APB_DW-1:0]         pwdata,
	input wire logic [swm_pkg::APB_DW-1:0]         prdata,
	input wire logic                               pready,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata
);

	import swm_pkg::*;

	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int FW = (CW > WIN_W) ? CW : WIN_W;

	logic win_wr_ok;

	assign win_wr_ok = psel && penable && pwrite && pready
		&& (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE)
		&& (pwdata[WIN_W-1:0] != '0)
		&& (FW'(pwdata[WIN_W-1:0]) <= FW'(WINDOW_MAX));

	// a held result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("median word changed while stalled");

	// a waiting sample word stays put
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("sample word changed while waiting");

	// input backpressure only comes from a stalled output
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// reset empties the output
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid during reset");

	// an in-range window size reads back as written
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		win_wr_ok ##1 (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE)
		|-> (prdata[WIN_W-1:0] == $past(pwdata[WIN_W-1:0]))
			&& (prdata[APB_DW-1:WIN_W] == '0))
		else $error("window_size readback mismatch");

endmodule : swm_checker

bind sliding_window_median_core swm_checker #(
	.WINDOW_MAX  (WINDOW_MAX),
	.SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (.*);

`default_nettype wire
